@@ src/sha_pkg.sv @@
// SHA-256 hasher package: types, round constants and round functions.
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef logic [31:0] word_t;

    localparam word_t H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ src/sha256_message_hasher.sv @@
// SHA-256 message hasher top level: byte intake, padding sequencer, digest output.
//
// Input channel (in_valid/in_ready): op=0 absorbs data_byte, op=1 finishes the
// message. Output channel (out_valid/out_ready): eight digest words, word 0
// first, last_word set on word 7.
// A data byte that fills a block starts a compression: 64 rounds of the single
// round unit plus an update step; no new byte is accepted until it is done.
// A finish request feeds padding bytes one per cycle through the same path,
// runs one or two compressions, then presents the eight words one per
// accepted output request. Output stalls simply hold the word; no new request
// is taken until the last word leaves.
// Reset loads the initial chaining values and clears the byte and bit counts.
// in_ready is high only in the idle state.
module sha256_message_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha_pkg::state_t state_reg, state_next;
    logic [5:0]      pos_reg, pos_next;
    logic [63:0]     bits_reg, bits_next;
    logic [63:0]     len_reg;
    logic [5:0]      t_reg, t_next;
    logic [2:0]      idx_reg, idx_next;
    logic            fin_reg, fin_next;
    logic            lblk_reg, lblk_next;
    logic [23:0]     acc_reg;
    sha_pkg::word_t  h_reg [8];
    sha_pkg::word_t  v [8];
    logic [7:0]      byte_in;
    logic            byte_we;
    logic            load;
    logic            step;
    logic            update;
    logic            out_reset;

    always_comb
    begin
        byte_in = data_byte;
        if (state_reg == sha_pkg::ST_PAD)
        begin
            if (!fin_reg)
            begin
                byte_in = sha_pkg::PAD_BYTE;
            end
            else if (lblk_reg && pos_reg >= sha_pkg::LEN_POS)
            begin
                byte_in = len_reg[63 - 8 * pos_reg[2:0] -: 8];
            end
            else
            begin
                byte_in = 8'h00;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        bits_next  = bits_reg;
        t_next     = t_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        lblk_next  = lblk_reg;
        byte_we    = 1'b0;
        load       = 1'b0;
        step       = 1'b0;
        update     = 1'b0;
        out_reset  = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op)
                    begin
                        fin_next   = 1'b0;
                        lblk_next  = (pos_reg < sha_pkg::LEN_POS);
                        state_next = sha_pkg::ST_PAD;
                    end
                    else
                    begin
                        byte_we   = 1'b1;
                        bits_next = bits_reg + 64'd8;
                        pos_next  = pos_reg + 6'd1;
                        if (pos_reg == 6'd63)
                        begin
                            load       = 1'b1;
                            t_next     = 6'd0;
                            state_next = sha_pkg::ST_ROUND;
                        end
                    end
                end
            end
            sha_pkg::ST_PAD:
            begin
                byte_we  = 1'b1;
                fin_next = 1'b1;
                pos_next = pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                begin
                    load       = 1'b1;
                    t_next     = 6'd0;
                    state_next = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                step   = 1'b1;
                t_next = t_reg + 6'd1;
                if (t_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_UPDATE;
                end
            end
            sha_pkg::ST_UPDATE:
            begin
                update = 1'b1;
                if (fin_reg && lblk_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = sha_pkg::ST_OUT;
                end
                else if (fin_reg)
                begin
                    lblk_next  = 1'b1;
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        out_reset  = 1'b1;
                        bits_next  = 64'd0;
                        pos_next   = 6'd0;
                        fin_next   = 1'b0;
                        lblk_next  = 1'b0;
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    // pad stays active until length bytes reach the end of a block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            pos_reg   <= 6'd0;
            bits_reg  <= 64'd0;
            t_reg     <= 6'd0;
            idx_reg   <= 3'd0;
            fin_reg   <= 1'b0;
            lblk_reg  <= 1'b0;
            h_reg     <= sha_pkg::H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            bits_reg  <= bits_next;
            t_reg     <= t_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            lblk_reg  <= lblk_next;
            if (out_reset)
            begin
                h_reg <= sha_pkg::H_INIT;
            end
            else if (update)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sha_pkg::ST_IDLE && in_valid && op)
        begin
            len_reg <= bits_reg;
        end
        if (byte_we && pos_reg[1:0] != 2'd3)
        begin
            acc_reg <= {acc_reg[15:0], byte_in};
        end
    end

    sha_round u_round (
        .clk     (clk),
        .load    (load),
        .step    (step),
        .t       (t_reg),
        .h_in    (h_reg),
        .w_shift (byte_we && pos_reg[1:0] == 2'd3),
        .w_in    ({acc_reg, byte_in}),
        .v_out   (v)
    );

    assign in_ready    = (state_reg == sha_pkg::ST_IDLE);
    assign out_valid   = (state_reg == sha_pkg::ST_OUT);
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

endmodule

@@ src/sha_round.sv @@
// One SHA-256 round with message schedule window, stepped once per cycle while step is high.
module sha_round (
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic [5:0]        t,
    input  sha_pkg::word_t    h_in [8],
    input  logic              w_shift,
    input  sha_pkg::word_t    w_in,
    output sha_pkg::word_t    v_out [8]
);

    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t w_reg [16];
    sha_pkg::word_t w_new;
    sha_pkg::word_t wt;
    sha_pkg::word_t s0;
    sha_pkg::word_t s1;
    sha_pkg::word_t big0;
    sha_pkg::word_t big1;
    sha_pkg::word_t ch;
    sha_pkg::word_t maj;
    sha_pkg::word_t t1;
    sha_pkg::word_t t2;

    always_comb
    begin
        s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        wt = (t < 6'd16) ? w_reg[0] : w_new;
        big1 = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
             ^ sha_pkg::rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + ch + sha_pkg::round_k(t) + wt;
        big0 = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
             ^ sha_pkg::rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + maj;
    end

    // window has w[t] at the bottom for t < 16 and holds w[t-16..t-1] from t = 16; during fill, words enter at the top
    always_ff @(posedge clk)
    begin
        if (w_shift || step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_shift ? w_in : wt;
        end
        if (load)
        begin
            v_reg <= h_in;
        end
        else if (step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign v_out = v_reg;

endmodule

@@ src/sha_checker.sv @@
// Port-level checker for the SHA-256 hasher, bound to the top level.
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while digest pending");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last marker mismatch");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=> out_valid
            && word_index == $past(word_index) + 3'd1)
        else $error("digest word order broken");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(digest_word))
        else $error("digest word changed while stalled");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> in_ready)
        else $error("not idle after digest");

endmodule

bind sha256_message_hasher sha_checker u_sha_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);
